/* hw/rtl/mltt_pkg.sv */
// Shared types, widths, register codes and reset values of the thermal throttle.
package mltt_pkg;

    localparam int MAX_LEVELS     = 4;
    localparam int TEMP_W         = 8;
    localparam int CAP_W          = 22;
    localparam int LEVEL_W        = 3;
    localparam int HYST_W         = 6;
    localparam int CFG_INDEX_W    = 4;
    localparam int CFG_DATA_W     = 22;

    localparam int NUM_LEVELS_DEF = 4;
    localparam int HYSTERESIS_DEF = 5;

    // Register map: thresholds first, then caps
    localparam logic [CFG_INDEX_W-1:0] REG_THRESHOLD_BASE = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CAP_BASE       = 4'd4;

    typedef logic [TEMP_W-1:0]  t_temp;
    typedef logic [CAP_W-1:0]   t_cap;
    typedef logic [LEVEL_W-1:0] t_level;

    localparam t_temp [MAX_LEVELS-1:0] THRESHOLD_RESET = '{8'd85, 8'd75, 8'd68, 8'd63};
    localparam t_cap  [MAX_LEVELS-1:0] CAP_RESET       =
        '{22'd384000, 22'd918000, 22'd1350000, 22'd1728000};

    typedef struct packed {
        t_level level;
        logic   changed;
        t_cap   freq_cap;
        logic   unlimited;
        t_temp  trigger_temp;
        logic   trigger_valid;
        t_temp  cool_trip;
        logic   release_valid;
    } t_result;

endpackage

/* hw/rtl/mltt_cfg_regs.sv */
// Configuration register file: trip thresholds and frequency caps per level.
module mltt_cfg_regs #(
    parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    input  logic [mltt_pkg::CFG_INDEX_W-1:0]        i_cfg_index,
    input  logic [mltt_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    output mltt_pkg::t_temp [NUM_LEVELS-1:0]        o_thresholds,
    output mltt_pkg::t_cap  [NUM_LEVELS-1:0]        o_caps
);

    mltt_pkg::t_temp [NUM_LEVELS-1:0] r_thresholds;
    mltt_pkg::t_cap  [NUM_LEVELS-1:0] r_caps;

    // Writes to levels beyond NUM_LEVELS, or past the map, fall through and are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_thresholds[i] <= mltt_pkg::THRESHOLD_RESET[i];
                r_caps[i]       <= mltt_pkg::CAP_RESET[i];
            end
        end else if (i_cfg_valid) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                if (i_cfg_index == mltt_pkg::REG_THRESHOLD_BASE
                                   + mltt_pkg::CFG_INDEX_W'(i)) begin
                    r_thresholds[i] <= i_cfg_data[mltt_pkg::TEMP_W-1:0];
                end
                if (i_cfg_index == mltt_pkg::REG_CAP_BASE
                                   + mltt_pkg::CFG_INDEX_W'(i)) begin
                    r_caps[i] <= i_cfg_data[mltt_pkg::CAP_W-1:0];
                end
            end
        end
    end

    assign o_thresholds = r_thresholds;
    assign o_caps       = r_caps;

endmodule

/* hw/rtl/mltt_level_logic.sv */
// Next-level decision with hysteresis and the trip/cap lookup for one sample.
module mltt_level_logic #(
    parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF,
    parameter int HYSTERESIS = mltt_pkg::HYSTERESIS_DEF
) (
    input  mltt_pkg::t_temp                     i_temperature,
    input  mltt_pkg::t_level                    i_cur_level,
    input  mltt_pkg::t_temp [NUM_LEVELS-1:0]    i_thresholds,
    input  mltt_pkg::t_cap  [NUM_LEVELS-1:0]    i_caps,
    output mltt_pkg::t_result                   o_result
);

    localparam mltt_pkg::t_temp HYST      = mltt_pkg::TEMP_W'(HYSTERESIS);
    localparam mltt_pkg::t_level TOP_CODE = mltt_pkg::LEVEL_W'(NUM_LEVELS);

    mltt_pkg::t_level cand;
    mltt_pkg::t_level next_level;
    mltt_pkg::t_temp  cur_thr;
    mltt_pkg::t_temp  next_thr;
    mltt_pkg::t_temp  cur_release;
    mltt_pkg::t_temp  next_release;
    mltt_pkg::t_temp  trig_thr;
    mltt_pkg::t_cap   next_cap;

    // Highest level whose threshold the sample meets
    always_comb begin
        cand = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i_temperature >= i_thresholds[i]) begin
                cand = mltt_pkg::LEVEL_W'(i + 1);
            end
        end
    end

    // Entry threshold of the current level
    always_comb begin
        cur_thr = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i_cur_level == mltt_pkg::LEVEL_W'(i + 1)) begin
                cur_thr = i_thresholds[i];
            end
        end
    end

    // Select entry threshold and cap of the next level, and the threshold of the level above
    always_comb begin
        next_thr = '0;
        trig_thr = '0;
        next_cap = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (next_level == mltt_pkg::LEVEL_W'(i + 1)) begin
                next_thr = i_thresholds[i];
                next_cap = i_caps[i];
            end
            if (next_level == mltt_pkg::LEVEL_W'(i)) begin
                trig_thr = i_thresholds[i];
            end
        end
    end

    // Saturating release points; none maps to zero through the select defaults
    assign cur_release  = (cur_thr  > HYST) ? cur_thr  - HYST : '0;
    assign next_release = (next_thr > HYST) ? next_thr - HYST : '0;

    // Rise at once; fall only at or below the release point; unthrottled follows the candidate
    always_comb begin
        priority if (cand > i_cur_level) begin
            next_level = cand;
        end else if (i_cur_level == '0) begin
            next_level = cand;
        end else if (i_temperature <= cur_release) begin
            next_level = cand;
        end else begin
            next_level = i_cur_level;
        end
    end

    always_comb begin
        o_result.level         = next_level;
        o_result.changed       = (next_level != i_cur_level);
        o_result.unlimited     = (next_level == '0);
        o_result.freq_cap      = next_cap;
        o_result.trigger_valid = (next_level < TOP_CODE);
        o_result.trigger_temp  = (next_level < TOP_CODE) ? trig_thr : '0;
        o_result.cool_trip     = next_release;
        o_result.release_valid = (next_level != '0) && (next_release != '0);
    end

endmodule

/* hw/rtl/multi_level_thermal_throttle.sv */
// Top level of the multi-level thermal throttle with hysteresis.
//
// Each temperature sample transfer yields exactly one result transfer carrying
// the new throttle level (0 = none, k = level k), a changed flag, the
// frequency cap of that level (or the unlimited flag) and the warm and cool
// trip points to program next. The block climbs to a higher level at once and
// drops only when the sample is at or below the current level's threshold less
// HYSTERESIS (saturating at zero). Samples pass an input register, one stage of
// comparators and selects, and a result register; one sample is taken every
// cycle while results are drained. The level register is updated as each
// sample leaves the input register, so consecutive samples see each other's
// outcome. Thresholds and caps sit at register indices 0..3 and 4..7; write
// them only while no sample is in flight. Writes to levels at or above
// NUM_LEVELS or to indices past the map are dropped. The configuration port
// never stalls.
module multi_level_thermal_throttle #(
    parameter int NUM_LEVELS = mltt_pkg::NUM_LEVELS_DEF,   // 1..4
    parameter int HYSTERESIS = mltt_pkg::HYSTERESIS_DEF    // 0..63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,

    // Configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mltt_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [mltt_pkg::CFG_DATA_W-1:0]     i_cfg_data,

    // Sample channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [mltt_pkg::TEMP_W-1:0]         i_temperature,

    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [mltt_pkg::LEVEL_W-1:0]        o_level,
    output logic                                o_changed,
    output logic [mltt_pkg::CAP_W-1:0]          o_freq_cap,
    output logic                                o_unlimited,
    output logic [mltt_pkg::TEMP_W-1:0]         o_trigger_temp,
    output logic                                o_trigger_valid,
    output logic [mltt_pkg::TEMP_W-1:0]         o_cool_trip,
    output logic                                o_release_valid
);

    mltt_pkg::t_temp [NUM_LEVELS-1:0] thresholds;
    mltt_pkg::t_cap  [NUM_LEVELS-1:0] caps;

    // Input stage
    logic              r_in_valid;
    mltt_pkg::t_temp   r_temp;

    // Result stage
    logic              r_out_valid;
    mltt_pkg::t_result r_out;

    // Throttle state
    mltt_pkg::t_level  r_level;

    mltt_pkg::t_result n_result;
    logic              advance;

    assign o_cfg_ready = 1'b1;

    mltt_cfg_regs #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_cfg_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_thresholds (thresholds),
        .o_caps       (caps)
    );

    mltt_level_logic #(
        .NUM_LEVELS (NUM_LEVELS),
        .HYSTERESIS (HYSTERESIS)
    ) u_level_logic (
        .i_temperature (r_temp),
        .i_cur_level   (r_level),
        .i_thresholds  (thresholds),
        .i_caps        (caps),
        .o_result      (n_result)
    );

    // Move the held sample on whenever the result register is free or being emptied
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_level     <= '0;
        end else begin
            // Hold the sample until it can advance; refill on a transfer
            if (i_in_valid && o_in_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_level     <= n_result.level;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_temp <= i_temperature;
        end
        if (advance) begin
            r_out <= n_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level         = r_out.level;
    assign o_changed       = r_out.changed;
    assign o_freq_cap      = r_out.freq_cap;
    assign o_unlimited     = r_out.unlimited;
    assign o_trigger_temp  = r_out.trigger_temp;
    assign o_trigger_valid = r_out.trigger_valid;
    assign o_cool_trip     = r_out.cool_trip;
    assign o_release_valid = r_out.release_valid;

endmodule

/* verif/multi_level_thermal_throttle_tb.sv */
// Self-checking testbench for the multi-level thermal throttle with hysteresis.
`timescale 1ns / 1ps

module multi_level_thermal_throttle_tb;
    import mltt_pkg::*;

    localparam int NUM_LEVELS      = NUM_LEVELS_DEF;
    localparam int HYSTERESIS      = HYSTERESIS_DEF;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int DRAIN_CYCLES    = 10;
    localparam int TIMEOUT_NS      = 2_000_000;
    localparam int LVL_IDX_W       = $clog2(MAX_LEVELS);

    // Idle percentages per random phase: sender light / receiver heavy, swapped, none
    localparam int SEND_IDLE_PCT[3] = '{16, 69, 0};
    localparam int RECV_IDLE_PCT[3] = '{69, 16, 0};

    // Indices past the register map; writes there must be dropped
    localparam logic [CFG_INDEX_W-1:0] REG_MAP_END    =
        REG_CAP_BASE + CFG_INDEX_W'(MAX_LEVELS);
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_LAST = '1;

    localparam t_level LEVEL_NONE = '0;
    localparam t_level LEVEL_TOP  = t_level'(NUM_LEVELS);

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;
    typedef enum int {SETTING_SORTED, SETTING_EXTREME, SETTING_ANY} t_setting;

    // One line of the directed stimulus table
    typedef struct {
        t_row_kind                kind;
        logic [CFG_INDEX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]    data;
        t_temp                    temp;
        bit                       known;
        t_result                  result;
    } t_row;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_INDEX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_ready;
    t_temp                    i_temperature;
    logic                     o_out_valid;
    logic                     i_out_ready;
    t_level                   o_level;
    logic                     o_changed;
    t_cap                     o_freq_cap;
    logic                     o_unlimited;
    t_temp                    o_trigger_temp;
    logic                     o_trigger_valid;
    t_temp                    o_cool_trip;
    logic                     o_release_valid;

    // Shadow copy of the block: thresholds, caps and the current level
    t_temp   shadow_threshold[MAX_LEVELS];
    t_cap    shadow_cap[MAX_LEVELS];
    t_level  shadow_level;

    // Expected results in transfer order
    t_result predicted_q[$];
    t_row    directed_rows[$];

    // Typed-in expectation that travels with the sample currently offered
    bit      row_known;
    t_result row_result;

    int      send_idle_pct;
    int      recv_idle_pct;
    int      hold_request;
    int      samples_taken;
    int      results_checked;
    int      regs_written;
    int      mismatch_count;

    multi_level_thermal_throttle #(
        .NUM_LEVELS (NUM_LEVELS),
        .HYSTERESIS (HYSTERESIS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_temperature   (i_temperature),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_level         (o_level),
        .o_changed       (o_changed),
        .o_freq_cap      (o_freq_cap),
        .o_unlimited     (o_unlimited),
        .o_trigger_temp  (o_trigger_temp),
        .o_trigger_valid (o_trigger_valid),
        .o_cool_trip     (o_cool_trip),
        .o_release_valid (o_release_valid)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case a transfer never completes
    initial begin
        #(TIMEOUT_NS);
        $display("Some tests failed");
        $finish;
    end

    // Release point of a level: its threshold less the hysteresis, floored at zero.
    // Level none has no release point.
    function automatic t_temp release_point(input t_level lvl);
        int t;
        if (lvl == LEVEL_NONE) return '0;
        t = int'(shadow_threshold[LVL_IDX_W'(lvl - 1)]);
        return t_temp'((t > HYSTERESIS) ? t - HYSTERESIS : 0);
    endfunction

    // Work out the result of one sample and advance the shadow level
    function automatic t_result throttle_step(input t_temp temp);
        int      cand;
        t_level  nxt;
        t_temp   rel;
        t_result r;
        cand = 0;
        // Highest level whose threshold is met, order of thresholds notwithstanding
        for (int k = 0; k < NUM_LEVELS; k++) begin
            if (temp >= shadow_threshold[k]) cand = k + 1;
        end
        nxt = shadow_level;
        // Climb at once; drop only once the sample has cooled to or below the release point
        if (cand > int'(shadow_level) || shadow_level == LEVEL_NONE ||
            temp <= release_point(shadow_level)) begin
            nxt = t_level'(cand);
        end
        r.level     = nxt;
        r.changed   = (nxt != shadow_level);
        r.unlimited = (nxt == LEVEL_NONE);
        r.freq_cap  = (nxt == LEVEL_NONE) ? '0 : shadow_cap[LVL_IDX_W'(nxt - 1)];
        if (nxt >= LEVEL_TOP) begin
            r.trigger_temp  = '0;
            r.trigger_valid = 1'b0;
        end else begin
            r.trigger_temp  = shadow_threshold[LVL_IDX_W'(nxt)];
            r.trigger_valid = 1'b1;
        end
        rel               = release_point(nxt);
        r.cool_trip       = rel;
        r.release_valid   = (nxt != LEVEL_NONE) && (rel != '0);
        shadow_level      = nxt;
        return r;
    endfunction

    // Mirror a register write; unmapped indices are dropped, data is cut to width
    function automatic void shadow_write(input logic [CFG_INDEX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        if (idx < REG_CAP_BASE)
            shadow_threshold[LVL_IDX_W'(idx - REG_THRESHOLD_BASE)] = data[TEMP_W-1:0];
        else if (idx < REG_MAP_END)
            shadow_cap[LVL_IDX_W'(idx - REG_CAP_BASE)] = data[CAP_W-1:0];
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Sample every transfer at the rising edge; inputs are stable since they move on the fall
    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        t_result calc;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                got = '{o_level, o_changed, o_freq_cap, o_unlimited,
                        o_trigger_temp, o_trigger_valid, o_cool_trip, o_release_valid};
                if (predicted_q.size() == 0) begin
                    $error("result transfer with no sample outstanding");
                    mismatch_count++;
                end else begin
                    want = predicted_q.pop_front();
                    check_field("level", want.level, got.level);
                    check_field("changed", want.changed, got.changed);
                    check_field("freq_cap", want.freq_cap, got.freq_cap);
                    check_field("unlimited", want.unlimited, got.unlimited);
                    check_field("trigger_temp", want.trigger_temp, got.trigger_temp);
                    check_field("trigger_valid", want.trigger_valid, got.trigger_valid);
                    check_field("cool_trip", want.cool_trip, got.cool_trip);
                    check_field("release_valid", want.release_valid, got.release_valid);
                    results_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                // Advance the shadow state always; a typed-in row overrides the prediction
                calc = throttle_step(i_temperature);
                predicted_q.push_back(row_known ? row_result : calc);
                samples_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                shadow_write(i_cfg_index, i_cfg_data);
                regs_written++;
            end
        end
    end

    // Result side: random back-pressure, plus a long hold-off whenever one is requested
    initial begin : result_sink
        int hold_left;
        hold_left   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Offer one sample and hold it until transferred; return at the next falling edge
    task automatic send_sample(input t_temp temp, input bit known, input t_result result);
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_temperature <= temp;
        row_known     <= known;
        row_result    <= result;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    // Write one register once every outstanding result has come back
    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_in_valid <= 1'b0;
        while (predicted_q.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    function automatic void add_sample(input t_temp temp, input bit known,
                                       input t_result result);
        directed_rows.push_back('{ROW_SAMPLE, '0, '0, temp, known, result});
    endfunction

    function automatic void add_write(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        directed_rows.push_back('{ROW_WRITE, idx, data, '0, 1'b0, '0});
    endfunction

    // Mostly hover around the thresholds and release points, where the decisions are made
    function automatic t_temp pick_temperature();
        int sel;
        int t;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            t = int'(shadow_threshold[LVL_IDX_W'($urandom_range(0, NUM_LEVELS - 1))])
                + int'($urandom_range(0, 16)) - 8;
        else if (sel < 9)
            t = $urandom_range(0, 255);
        else
            t = $urandom_range(0, 1) ? 255 : 0;
        if (t < 0) t = 0;
        if (t > 255) t = 255;
        return t_temp'(t);
    endfunction

    // Load a full register setting for one random phase
    task automatic program_setting(input t_setting setting);
        logic [CFG_DATA_W-1:0] junk;
        t_temp                 thr;
        t_cap                  cap;
        int                    floor_t;
        floor_t = $urandom_range(0, 60);
        for (int k = 0; k < MAX_LEVELS; k++) begin
            // Random upper bits on threshold writes check that they are cut off
            junk = CFG_DATA_W'($urandom);
            case (setting)
                SETTING_SORTED: begin
                    floor_t = floor_t + $urandom_range(1, 40);
                    thr     = t_temp'((floor_t > 255) ? 255 : floor_t);
                    cap     = t_cap'($urandom);
                end
                SETTING_EXTREME: begin
                    thr = (k == 0) ? 8'd0 : (k == 1) ? 8'd3 : 8'd255;
                    cap = (k % 2 == 0) ? '0 : '1;
                end
                default: begin
                    thr = t_temp'($urandom);
                    cap = t_cap'($urandom);
                end
            endcase
            reg_write(REG_THRESHOLD_BASE + CFG_INDEX_W'(k),
                      {junk[CFG_DATA_W-1:TEMP_W], thr});
            reg_write(REG_CAP_BASE + CFG_INDEX_W'(k), cap);
        end
        reg_write(REG_MAP_END
                  + CFG_INDEX_W'($urandom_range(0, REG_INDEX_LAST - REG_MAP_END)),
                  CFG_DATA_W'($urandom));
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        i_in_valid      = 1'b0;
        i_temperature   = '0;
        row_known       = 1'b0;
        row_result      = '0;
        send_idle_pct   = SEND_IDLE_PCT[0];
        recv_idle_pct   = RECV_IDLE_PCT[0];
        hold_request    = 0;
        samples_taken   = 0;
        results_checked = 0;
        regs_written    = 0;
        mismatch_count  = 0;
        shadow_level    = LEVEL_NONE;
        for (int k = 0; k < MAX_LEVELS; k++) begin
            shadow_threshold[k] = THRESHOLD_RESET[k];
            shadow_cap[k]       = CAP_RESET[k];
        end

        // Reset settings: cold start, jump to the top, walk down through every release
        // point (most after a near miss), walk up one level at a time, then drop straight out
        add_sample(8'd0, 1'b1, '{LEVEL_NONE, 1'b0, '0, 1'b1,
                                 THRESHOLD_RESET[0], 1'b1, 8'd0, 1'b0});
        add_sample(8'd255, 1'b1, '{LEVEL_TOP, 1'b1, CAP_RESET[NUM_LEVELS - 1], 1'b0,
                                   8'd0, 1'b0,
                                   THRESHOLD_RESET[NUM_LEVELS - 1] - t_temp'(HYSTERESIS),
                                   1'b1});
        add_sample(8'd81, 1'b0, '0);
        add_sample(8'd80, 1'b0, '0);
        add_sample(8'd71, 1'b0, '0);
        add_sample(8'd70, 1'b0, '0);
        add_sample(8'd63, 1'b0, '0);
        add_sample(8'd59, 1'b0, '0);
        add_sample(8'd58, 1'b0, '0);
        add_sample(8'd62, 1'b0, '0);
        add_sample(8'd63, 1'b0, '0);
        add_sample(8'd68, 1'b0, '0);
        add_sample(8'd75, 1'b0, '0);
        add_sample(8'd85, 1'b0, '0);
        add_sample(8'd0, 1'b1, '{LEVEL_NONE, 1'b1, '0, 1'b1,
                                 THRESHOLD_RESET[0], 1'b1, 8'd0, 1'b0});
        // Unordered thresholds, a threshold below the hysteresis (release floors at zero,
        // written with junk upper bits), extreme caps and writes past the map
        add_write(REG_THRESHOLD_BASE + CFG_INDEX_W'(0), 22'h3FFF02);
        add_write(REG_THRESHOLD_BASE + CFG_INDEX_W'(1), 22'd200);
        add_write(REG_THRESHOLD_BASE + CFG_INDEX_W'(2), 22'd100);
        add_write(REG_THRESHOLD_BASE + CFG_INDEX_W'(3), 22'd255);
        add_write(REG_CAP_BASE + CFG_INDEX_W'(0), '0);
        add_write(REG_CAP_BASE + CFG_INDEX_W'(3), '1);
        add_write(REG_MAP_END, 22'h2AAAAA);
        add_write(REG_INDEX_LAST, '1);
        add_sample(8'd1, 1'b0, '0);
        add_sample(8'd2, 1'b0, '0);
        add_sample(8'd100, 1'b0, '0);
        add_sample(8'd150, 1'b0, '0);
        add_sample(8'd96, 1'b0, '0);
        add_sample(8'd95, 1'b0, '0);
        add_sample(8'd255, 1'b0, '0);
        add_sample(8'd250, 1'b0, '0);
        add_sample(8'd0, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_WRITE)
                reg_write(directed_rows[r].index, directed_rows[r].data);
            else
                send_sample(directed_rows[r].temp, directed_rows[r].known,
                            directed_rows[r].result);
        end

        // Random phases, each under its own register setting and idling profile
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = SEND_IDLE_PCT[ph];
            recv_idle_pct = RECV_IDLE_PCT[ph];
            program_setting(t_setting'(ph));
            // Back up the result side while samples keep coming, so the input stalls
            if (ph == 2) hold_request = HOLD_OFF_CYCLES;
            repeat (ITEMS_PER_PHASE) send_sample(pick_temperature(), 1'b0, '0);
        end

        i_in_valid <= 1'b0;
        while (predicted_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (predicted_q.size() != 0) mismatch_count++;

        $display("Checked %0d results from %0d samples and %0d register writes",
                 results_checked, samples_taken, regs_written);
        $display("over sorted, extreme and unordered settings with mixed back-pressure");
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
